>>> rtl/core/haptic_wall_force_controller_core_defines.svh
// Assertion macros for the haptic wall force controller core
`ifndef HAPTIC_WALL_FORCE_CONTROLLER_CORE_DEFINES_SVH
`define HAPTIC_WALL_FORCE_CONTROLLER_CORE_DEFINES_SVH
// assert that an antecedent implies a consequent in the next cycle
`define HWFC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
// assert that an expression holds at every edge out of reset
`define HWFC_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: check failed");
`endif

>>> rtl/core/hwfc_pkg.sv
// Shared types and constants for the haptic wall force controller
package hwfc_pkg;
   localparam int AngleBits = 12;
   localparam int FracBits = 8;
   localparam int GainBits = 16;
   localparam int ForceBits = 25;
   localparam int FiltBits = 34;
   localparam int ErrBits = 36;
   localparam int AccBits = 56;
   localparam int RegIdxBits = 3;
   localparam int CsrDataBits = 16;
   localparam int CurrentMax = 1200;
   localparam int ErrOffset = 3000;
   localparam int ErrDeadband = 1500;
   // divider width: numerator magnitude up to 2^36, quotient fits
   localparam int DivBits = 40;
   localparam int DivCntBits = 6;
   localparam int MulCntBits = 6;

   typedef enum logic [RegIdxBits-1:0] {
      REG_WALL_LOW   = 3'd0,
      REG_FREE_LOW   = 3'd1,
      REG_FREE_HIGH  = 3'd2,
      REG_WALL_HIGH  = 3'd3,
      REG_WALL_FMAX  = 3'd4,
      REG_ASSIST     = 3'd5,
      REG_PROP_GAIN  = 3'd6,
      REG_DERIV_GAIN = 3'd7
   } reg_idx_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FILT_START,
      ST_FILT_WAIT,
      ST_RAMP_START,
      ST_RAMP_WAIT,
      ST_ERROR,
      ST_MUL_P_START,
      ST_MUL_P_WAIT,
      ST_MUL_D_START,
      ST_MUL_D_WAIT,
      ST_FINISH,
      ST_OUTPUT
   } state_type;
endpackage

>>> rtl/core/hwfc_if.sv
// Valid/ready channel interfaces for request and response items
interface hwfc_req_if (input logic clock);
   logic valid;
   logic ready;
   logic [hwfc_pkg::AngleBits-1:0] angle;
   logic signed [hwfc_pkg::ForceBits-1:0] force_sample;
   modport source (output valid, angle, force_sample, input ready);
   modport sink (input valid, angle, force_sample, output ready);
endinterface

interface hwfc_rsp_if (input logic clock);
   logic valid;
   logic ready;
   logic signed [11:0] drive_current;
   logic signed [15:0] target_force;
   logic signed [hwfc_pkg::ForceBits-1:0] filtered_force;
   logic clamped;
   modport source (output valid, drive_current, target_force, filtered_force, clamped,
                   input ready);
   modport sink (input valid, drive_current, target_force, filtered_force, clamped,
                 output ready);
endinterface

>>> rtl/core/hwfc_divider.sv
// Bit-serial unsigned restoring divider, one quotient bit per cycle
module hwfc_divider (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [hwfc_pkg::DivBits-1:0] numer,
   input  logic [hwfc_pkg::DivBits-1:0] denom,
   output logic [hwfc_pkg::DivBits-1:0] quot,
   output logic done
);
   logic [hwfc_pkg::DivBits-1:0] quot_ff, quot_in;
   logic [hwfc_pkg::DivBits-1:0] rem_ff, rem_in;
   logic [hwfc_pkg::DivBits-1:0] den_ff, den_in;
   logic [hwfc_pkg::DivCntBits-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [hwfc_pkg::DivBits:0] trial;
   logic [hwfc_pkg::DivBits-1:0] shifted;

   always_comb begin
      shifted = {rem_ff[hwfc_pkg::DivBits-2:0], quot_ff[hwfc_pkg::DivBits-1]};
      trial = {1'b0, shifted} - {1'b0, den_ff};
      quot_in = quot_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = numer;
         rem_in = '0;
         den_in = denom;
         cnt_in = hwfc_pkg::DivCntBits'(hwfc_pkg::DivBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in the next numerator bit, subtract when it fits
         if (!trial[hwfc_pkg::DivBits]) begin
            rem_in = trial[hwfc_pkg::DivBits-1:0];
         end else begin
            rem_in = shifted;
         end
         quot_in = {quot_ff[hwfc_pkg::DivBits-2:0], ~trial[hwfc_pkg::DivBits]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == hwfc_pkg::DivCntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quot = quot_ff;
   assign done = done_ff;
endmodule

>>> rtl/core/hwfc_multiplier.sv
// Shift-add signed multiplier: unsigned 16-bit gain by signed operand, one bit per cycle
module hwfc_multiplier (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic [hwfc_pkg::GainBits-1:0] gain,
   input  logic signed [hwfc_pkg::ErrBits:0] operand,
   output logic signed [hwfc_pkg::AccBits-1:0] product,
   output logic done
);
   logic signed [hwfc_pkg::AccBits-1:0] acc_ff, acc_in;
   logic signed [hwfc_pkg::AccBits-1:0] mcand_ff, mcand_in;
   logic [hwfc_pkg::GainBits-1:0] gain_ff, gain_in;
   logic [hwfc_pkg::MulCntBits-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      gain_in = gain_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         acc_in = '0;
         mcand_in = hwfc_pkg::AccBits'(operand);
         gain_in = gain;
         cnt_in = hwfc_pkg::MulCntBits'(hwfc_pkg::GainBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // add the shifted operand for each set gain bit
         if (gain_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff <<< 1;
         gain_in = gain_ff >> 1;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == hwfc_pkg::MulCntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      gain_ff <= gain_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign product = acc_ff;
   assign done = done_ff;
endmodule

>>> rtl/core/haptic_wall_force_controller_core.sv
// Haptic wall force controller core: control tick sequencer and state registers
// One request item per control tick gives one response item. The tick runs as a
// sequence over a shared bit-serial divider (one quotient bit per cycle) and a
// shift-add multiplier (one gain bit per cycle): the force filter takes one
// division, a ramp angle a second, and the PD law two multiplications. Once the
// response is presented the core returns to idle, where it takes the next
// request, so it takes no new request before it is through with the last.
// Only one item is in flight; a response still waiting for its receiver holds
// the next item in the output state until it is taken.
// Configuration registers are written through the csr_ port at any edge with
// csr_write_enable high and are meant to be changed only while the core idles.
module haptic_wall_force_controller_core (
   input  logic clock,
   input  logic reset,
   hwfc_req_if.sink req,
   hwfc_rsp_if.source rsp,
   input  logic csr_write_enable,
   input  logic [hwfc_pkg::RegIdxBits-1:0] csr_index,
   input  logic [hwfc_pkg::CsrDataBits-1:0] csr_write_data
);
   localparam int AB = hwfc_pkg::AngleBits;
   localparam int FB = hwfc_pkg::FracBits;
   localparam int DB = hwfc_pkg::DivBits;
   localparam int EB = hwfc_pkg::ErrBits;
   localparam int PB = hwfc_pkg::AccBits;

   // configuration registers
   logic [11:0] wall_low_ff, free_low_ff, free_high_ff, wall_high_ff;
   logic [14:0] wall_fmax_ff, assist_ff;
   logic [15:0] prop_gain_ff, deriv_gain_ff;

   // persistent state
   logic [AB-1:0] last_angle_ff, last_angle_in;
   logic signed [hwfc_pkg::FiltBits-1:0] filt_ff, filt_in;
   logic signed [EB-1:0] last_err_ff, last_err_in;

   // per-item working registers
   hwfc_pkg::state_type state_ff, state_in;
   logic [AB-1:0] angle_ff, angle_in;
   logic signed [hwfc_pkg::ForceBits-1:0] force_ff, force_in;
   logic signed [16:0] target_ff, target_in;
   logic signed [EB-1:0] err_ff, err_in;
   logic signed [PB-1:0] acc_ff, acc_in;
   logic signed [11:0] cur_ff, cur_in;
   logic clamp_ff, clamp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic div_start, div_done, mul_start, mul_done;
   logic [DB-1:0] div_numer, div_denom, div_quot;
   logic [hwfc_pkg::GainBits-1:0] mul_gain;
   logic signed [EB:0] mul_operand;
   logic signed [PB-1:0] mul_product;

   // combinational helpers
   logic signed [AB+1:0] delta;
   logic signed [hwfc_pkg::FiltBits+2:0] filt_sum;
   logic [DB-1:0] filt_mag;
   logic left_ramp, wall_left, wall_right, free_zone;
   logic [12:0] ramp_span, ramp_dist;
   logic [DB-1:0] ramp_mag;
   logic signed [EB+1:0] err_raw, err_off;
   logic signed [PB-1:0] limit_pos;
   logic [PB-1:0] acc_mag;
   logic [PB-1:0] cur_mag;
   logic filt_neg_ff, filt_neg_in;

   hwfc_divider u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .numer(div_numer), .denom(div_denom), .quot(div_quot), .done(div_done)
   );

   hwfc_multiplier u_mul (
      .clock(clock), .reset(reset), .start(mul_start),
      .gain(mul_gain), .operand(mul_operand), .product(mul_product), .done(mul_done)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         wall_low_ff <= 12'd2050;
         free_low_ff <= 12'd2350;
         free_high_ff <= 12'd3150;
         wall_high_ff <= 12'd3450;
         wall_fmax_ff <= 15'd25000;
         assist_ff <= 15'd5000;
         prop_gain_ff <= 16'd1966;
         deriv_gain_ff <= 16'd3277;
      end else if (csr_write_enable) begin
         unique case (hwfc_pkg::reg_idx_type'(csr_index))
            hwfc_pkg::REG_WALL_LOW:   wall_low_ff <= csr_write_data[11:0];
            hwfc_pkg::REG_FREE_LOW:   free_low_ff <= csr_write_data[11:0];
            hwfc_pkg::REG_FREE_HIGH:  free_high_ff <= csr_write_data[11:0];
            hwfc_pkg::REG_WALL_HIGH:  wall_high_ff <= csr_write_data[11:0];
            hwfc_pkg::REG_WALL_FMAX:  wall_fmax_ff <= csr_write_data[14:0];
            hwfc_pkg::REG_ASSIST:     assist_ff <= csr_write_data[14:0];
            hwfc_pkg::REG_PROP_GAIN:  prop_gain_ff <= csr_write_data;
            hwfc_pkg::REG_DERIV_GAIN: deriv_gain_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // datapath decode
   always_comb begin
      // wrapped angle change
      delta = $signed({2'b00, angle_ff}) - $signed({2'b00, last_angle_ff});
      if (delta > $signed((AB+2)'(1 << (AB-1)))) begin
         delta = delta - $signed((AB+2)'(1 << AB));
      end else if (delta < -$signed((AB+2)'(1 << (AB-1)))) begin
         delta = delta + $signed((AB+2)'(1 << AB));
      end
      // filter numerator: old + 4 * force << frac, rounded magnitude
      filt_sum = (hwfc_pkg::FiltBits+3)'(filt_ff)
         + ((hwfc_pkg::FiltBits+3)'(force_ff) <<< (FB + 2));
      filt_mag = filt_sum[hwfc_pkg::FiltBits+2] ? DB'(-filt_sum) : DB'(filt_sum);
      wall_left = angle_ff <= wall_low_ff;
      wall_right = angle_ff >= wall_high_ff;
      free_zone = angle_ff >= free_low_ff && angle_ff <= free_high_ff;
      left_ramp = angle_ff < free_low_ff;
      ramp_span = left_ramp ? {1'b0, free_low_ff} - {1'b0, wall_low_ff}
                            : {1'b0, wall_high_ff} - {1'b0, free_high_ff};
      ramp_dist = left_ramp ? {1'b0, free_low_ff} - {1'b0, angle_ff}
                            : {1'b0, angle_ff} - {1'b0, free_high_ff};
      ramp_mag = DB'(wall_fmax_ff) * DB'(ramp_dist);
      // error with offset toward zero and deadband
      err_raw = ((EB+2)'(target_ff) <<< FB) - (EB+2)'(filt_ff);
      if (err_raw > 0) begin
         err_off = err_raw - (EB+2)'(hwfc_pkg::ErrOffset << FB);
      end else begin
         err_off = err_raw + (EB+2)'(hwfc_pkg::ErrOffset << FB);
      end
      if (err_off > -$signed((EB+2)'(hwfc_pkg::ErrDeadband << FB))
          && err_off < $signed((EB+2)'(hwfc_pkg::ErrDeadband << FB))) begin
         err_off = '0;
      end
      limit_pos = PB'(hwfc_pkg::CurrentMax) <<< (FB + hwfc_pkg::GainBits);
      acc_mag = acc_ff[PB-1] ? PB'(-acc_ff) : PB'(acc_ff);
      cur_mag = (acc_mag + (PB'(1) << (FB + hwfc_pkg::GainBits - 1)))
         >> (FB + hwfc_pkg::GainBits);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hwfc_pkg::ST_IDLE:       if (req.valid) state_in = hwfc_pkg::ST_FILT_START;
         hwfc_pkg::ST_FILT_START: state_in = hwfc_pkg::ST_FILT_WAIT;
         hwfc_pkg::ST_FILT_WAIT: begin
            if (div_done) begin
               if (wall_left || wall_right || free_zone) begin
                  state_in = hwfc_pkg::ST_ERROR;
               end else begin
                  state_in = hwfc_pkg::ST_RAMP_START;
               end
            end
         end
         hwfc_pkg::ST_RAMP_START: state_in = hwfc_pkg::ST_RAMP_WAIT;
         hwfc_pkg::ST_RAMP_WAIT:  if (div_done) state_in = hwfc_pkg::ST_ERROR;
         hwfc_pkg::ST_ERROR:      state_in = hwfc_pkg::ST_MUL_P_START;
         hwfc_pkg::ST_MUL_P_START: state_in = hwfc_pkg::ST_MUL_P_WAIT;
         hwfc_pkg::ST_MUL_P_WAIT: if (mul_done) state_in = hwfc_pkg::ST_MUL_D_START;
         hwfc_pkg::ST_MUL_D_START: state_in = hwfc_pkg::ST_MUL_D_WAIT;
         hwfc_pkg::ST_MUL_D_WAIT: if (mul_done) state_in = hwfc_pkg::ST_FINISH;
         hwfc_pkg::ST_FINISH:     state_in = hwfc_pkg::ST_OUTPUT;
         hwfc_pkg::ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp.ready) state_in = hwfc_pkg::ST_IDLE;
         end
         default: state_in = hwfc_pkg::ST_IDLE;
      endcase
   end

   // outputs and datapath updates
   always_comb begin
      angle_in = angle_ff;
      force_in = force_ff;
      last_angle_in = last_angle_ff;
      filt_in = filt_ff;
      filt_neg_in = filt_neg_ff;
      last_err_in = last_err_ff;
      target_in = target_ff;
      err_in = err_ff;
      acc_in = acc_ff;
      cur_in = cur_ff;
      clamp_in = clamp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      req.ready = 1'b0;
      div_start = 1'b0;
      mul_start = 1'b0;
      div_numer = filt_mag + DB'(2);
      div_denom = DB'(5);
      mul_gain = prop_gain_ff;
      mul_operand = (EB+1)'(err_ff);
      unique case (state_ff)
         hwfc_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               angle_in = req.angle;
               force_in = req.force_sample;
            end
         end
         hwfc_pkg::ST_FILT_START: begin
            div_start = 1'b1;
            filt_neg_in = filt_sum[hwfc_pkg::FiltBits+2];
            // assist on the way back takes precedence, then walls, else zero
            if (wall_left && delta > 0) begin
               target_in = 17'(assist_ff);
            end else if (wall_right && delta < 0) begin
               target_in = -17'(assist_ff);
            end else if (wall_left) begin
               target_in = 17'(wall_fmax_ff);
            end else if (wall_right) begin
               target_in = -17'(wall_fmax_ff);
            end else begin
               target_in = '0;
            end
            last_angle_in = angle_ff;
         end
         hwfc_pkg::ST_FILT_WAIT: begin
            if (div_done) begin
               filt_in = filt_neg_ff ? -hwfc_pkg::FiltBits'(div_quot)
                                     : hwfc_pkg::FiltBits'(div_quot);
            end
         end
         hwfc_pkg::ST_RAMP_START: begin
            div_start = 1'b1;
            div_numer = ramp_mag + DB'(ramp_span >> 1);
            div_denom = DB'(ramp_span);
         end
         hwfc_pkg::ST_RAMP_WAIT: begin
            if (div_done) begin
               target_in = left_ramp ? 17'(div_quot) : -17'(div_quot);
            end
         end
         hwfc_pkg::ST_ERROR: begin
            err_in = EB'(err_off);
         end
         hwfc_pkg::ST_MUL_P_START: begin
            mul_start = 1'b1;
         end
         hwfc_pkg::ST_MUL_P_WAIT: begin
            if (mul_done) acc_in = mul_product;
         end
         hwfc_pkg::ST_MUL_D_START: begin
            mul_start = 1'b1;
            mul_gain = deriv_gain_ff;
            mul_operand = (EB+1)'(err_ff) - (EB+1)'(last_err_ff);
         end
         hwfc_pkg::ST_MUL_D_WAIT: begin
            if (mul_done) acc_in = acc_ff + mul_product;
         end
         hwfc_pkg::ST_FINISH: begin
            last_err_in = err_ff;
            if (acc_ff > limit_pos) begin
               cur_in = 12'(hwfc_pkg::CurrentMax);
               clamp_in = 1'b1;
            end else if (acc_ff < -limit_pos) begin
               cur_in = -12'(hwfc_pkg::CurrentMax);
               clamp_in = 1'b1;
            end else begin
               cur_in = acc_ff[PB-1] ? -12'(cur_mag) : 12'(cur_mag);
               clamp_in = 1'b0;
            end
         end
         hwfc_pkg::ST_OUTPUT: begin
            // present once the response slot is free
            if (!rsp_valid_ff || rsp.ready) rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   logic signed [15:0] rsp_target_ff;
   logic signed [hwfc_pkg::ForceBits-1:0] rsp_filt_ff;
   logic signed [11:0] rsp_cur_ff;
   logic rsp_clamp_ff;

   always_ff @(posedge clock) begin
      angle_ff <= angle_in;
      force_ff <= force_in;
      target_ff <= target_in;
      err_ff <= err_in;
      acc_ff <= acc_in;
      cur_ff <= cur_in;
      clamp_ff <= clamp_in;
      filt_neg_ff <= filt_neg_in;
      if (state_ff == hwfc_pkg::ST_OUTPUT && (!rsp_valid_ff || rsp.ready)) begin
         rsp_target_ff <= target_ff[15:0];
         rsp_filt_ff <= filt_ff[FB +: hwfc_pkg::ForceBits];
         rsp_cur_ff <= cur_ff;
         rsp_clamp_ff <= clamp_ff;
      end
      if (reset) begin
         state_ff <= hwfc_pkg::ST_IDLE;
         last_angle_ff <= '0;
         filt_ff <= '0;
         last_err_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_angle_ff <= last_angle_in;
         filt_ff <= filt_in;
         last_err_ff <= last_err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.target_force = rsp_target_ff;
   assign rsp.filtered_force = rsp_filt_ff;
   assign rsp.drive_current = rsp_cur_ff;
   assign rsp.clamped = rsp_clamp_ff;
endmodule

>>> rtl/core/hwfc_checker.sv
// Port-level checks for the haptic wall force controller core
`include "haptic_wall_force_controller_core_defines.svh"
module hwfc_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic signed [11:0] drive_current,
   input logic clamped
);
   logic cur_ok, clamp_ok, take_req, rsp_wait;

   assign cur_ok = !rsp_valid
      || (drive_current <= 12'sd1200 && drive_current >= -12'sd1200);
   assign clamp_ok = !(rsp_valid && clamped)
      || drive_current == 12'sd1200 || drive_current == -12'sd1200;
   assign take_req = req_valid && req_ready;
   assign rsp_wait = rsp_valid && !rsp_ready;

   `HWFC_ASSERT_ALWAYS(a_cur_range, clock, reset, cur_ok)
   `HWFC_ASSERT_ALWAYS(a_clamp_edge, clock, reset, clamp_ok)
   `HWFC_ASSERT_NEXT(a_one_in_flight, clock, reset, take_req, !req_ready)
   `HWFC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid)
endmodule

bind haptic_wall_force_controller_core hwfc_checker u_hwfc_checker (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .drive_current(rsp.drive_current),
   .clamped(rsp.clamped)
);
